### rtl/bldim_pkg.sv
`timescale 1ns / 1ps

package bldim_pkg;

    // field widths
    localparam int BRIGHT_W   = 8;
    localparam int LVL_W      = 5;
    localparam int AUTO_W     = 8;
    localparam int BP_W       = 13;
    localparam int BP_REGS    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // defaults for the top level parameters
    localparam int NUM_BREAKPOINTS_DEF = 5;
    localparam int PULSE_MODULUS_DEF   = 32;

    // auto level at which outdoor mode takes over
    localparam logic [AUTO_W-1:0] HBM_THRESHOLD = AUTO_W'(6);

    // serial divider sizes: numerator holds brightness span times tune span
    localparam int DIV_NUM_W = BRIGHT_W + LVL_W;
    localparam int DIV_DEN_W = BRIGHT_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [BP_W-1:0] BP_RESET [BP_REGS] = '{
        13'd0, 13'd266, 13'd532, 13'd4224, 13'd8191
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BP_OFF,
        REG_BP_MIN,
        REG_BP_DIM,
        REG_BP_DEF,
        REG_BP_MAX,
        REG_OUTDOOR_TUNE,
        REG_AUTO_LEVEL,
        REG_START_LEVEL
    } t_cfg_idx;

    typedef struct packed {
        logic [BRIGHT_W-1:0] req_brightness;
        logic                blank;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [LVL_W-1:0] dim_level;
        logic             changed;
        logic             power_on;
        logic             power_off;
        logic [LVL_W-1:0] pulse_count;
    } t_out;

    typedef struct packed {
        logic [LVL_W-1:0]  outdoor_tune;
        logic [AUTO_W-1:0] auto_level;
        logic              prev_load;
        logic [LVL_W-1:0]  prev_value;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] len;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [BRIGHT_W-1:0] bp_bright(input logic [BP_W-1:0] e);
        return e[BRIGHT_W-1:0];
    endfunction

    function automatic logic [LVL_W-1:0] bp_tune(input logic [BP_W-1:0] e);
        return e[BRIGHT_W +: LVL_W];
    endfunction

endpackage

### rtl/bldim_div.sv
`timescale 1ns / 1ps

module bldim_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bldim_pkg::t_div_req i_req,
    output bldim_pkg::t_div_rsp o_rsp
);
    import bldim_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;
    logic [DIV_DEN_W:0]   w_diff;

    // one restoring step: bring down the next numerator bit
    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // load on start, then shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.len;
                r_num <= i_req.num;
                r_den <= i_req.den;
                r_rem <= '0;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                r_num  <= {r_num[DIV_NUM_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
    assign o_rsp.rem  = r_rem;

    // partial remainder must stay below the divisor while stepping
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

### rtl/bldim_cfg.sv
`timescale 1ns / 1ps

module bldim_cfg #(
    parameter int NUM_BREAKPOINTS = bldim_pkg::NUM_BREAKPOINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  bldim_pkg::t_cfg_idx             i_cfg_index,
    input  logic [bldim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [bldim_pkg::BP_W-1:0]      o_bp [NUM_BREAKPOINTS],
    output bldim_pkg::t_cfg                 o_cfg
);
    import bldim_pkg::*;

    localparam int BP_STORED = (NUM_BREAKPOINTS < BP_REGS) ? NUM_BREAKPOINTS : BP_REGS;

    logic [BP_W-1:0]   r_bp [BP_STORED];
    logic [LVL_W-1:0]  r_outdoor;
    logic [AUTO_W-1:0] r_auto;

    // hold register values, update on a write beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BP_STORED; i++) begin
                r_bp[i] <= BP_RESET[i];
            end
            r_outdoor <= LVL_W'(31);
            r_auto    <= '0;
        end else if (i_wr) begin
            for (int i = 0; i < BP_STORED; i++) begin
                if (i_cfg_index == t_cfg_idx'(i)) begin
                    r_bp[i] <= i_cfg_data[BP_W-1:0];
                end
            end
            unique case (i_cfg_index)
                REG_OUTDOOR_TUNE: r_outdoor <= i_cfg_data[LVL_W-1:0];
                REG_AUTO_LEVEL:   r_auto    <= i_cfg_data[AUTO_W-1:0];
                default: ;
            endcase
        end
    end

    // breakpoints past the writable ones read as zero
    for (genvar g = 0; g < NUM_BREAKPOINTS; g++) begin : g_bp
        if (g < BP_STORED) begin : g_reg
            assign o_bp[g] = r_bp[g];
        end else begin : g_zero
            assign o_bp[g] = '0;
        end
    end

    assign o_cfg.outdoor_tune = r_outdoor;
    assign o_cfg.auto_level   = r_auto;
    assign o_cfg.prev_load    = i_wr && (i_cfg_index == REG_START_LEVEL);
    assign o_cfg.prev_value   = i_cfg_data[LVL_W-1:0];

endmodule

### rtl/backlight_level_pulse_dimmer_top.sv
`timescale 1ns / 1ps

// Backlight level dimmer: maps a requested brightness (forced to 0 when blanked)
// through a table of NUM_BREAKPOINTS packed breakpoints (tune*256 + brightness)
// to a 5-bit tune level and reports how the driver must move from the stored
// level: power-off, power-on, and a count of low pulses (old - new) mod
// PULSE_MODULUS. One item is worked on at a time. The breakpoint search steps
// through the breakpoints in order, and interpolation and the pulse count share
// one bit-serial restoring divider that yields one bit per cycle, first the
// interpolation quotient and then the pulse count. An item out of range skips
// the search and the divider, and an item also waits while an earlier result
// beat is held by the stall; its result beat shows in the same cycle that the
// next item can be taken. The result register lets the next item be taken
// while that beat waits. Register writes are taken every cycle; writing
// start_level also loads the stored level.
module backlight_level_pulse_dimmer_top #(
    parameter int NUM_BREAKPOINTS = bldim_pkg::NUM_BREAKPOINTS_DEF,
    parameter int PULSE_MODULUS   = bldim_pkg::PULSE_MODULUS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bldim_pkg::t_in                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bldim_pkg::t_out                  o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  bldim_pkg::t_cfg_idx              i_cfg_index,
    input  logic [bldim_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bldim_pkg::*;

    localparam int IDX_W   = $clog2(NUM_BREAKPOINTS);
    localparam int TOP     = NUM_BREAKPOINTS - 1;
    // offset that keeps old - new + offset non-negative and congruent mod M
    localparam int MOD_OFS = ((31 + PULSE_MODULUS - 1) / PULSE_MODULUS) * PULSE_MODULUS;
    localparam int MOD_W   = $clog2(31 + MOD_OFS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_MOD,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [BRIGHT_W-1:0] r_b;
    logic [IDX_W-1:0]  r_idx;
    logic [BP_W-1:0]   r_lo;
    logic [BP_W-1:0]   r_hi;
    logic              r_neg;
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  r_prev;
    t_out              r_res;
    t_out              r_out;
    logic              r_out_valid;

    logic [BP_W-1:0]   w_bp [NUM_BREAKPOINTS];
    t_cfg              w_cfg;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic              w_cfg_wr;

    logic [BP_W-1:0]     w_top;
    logic [BP_W-1:0]     w_cur;
    logic [BRIGHT_W-1:0] w_bdiff;
    logic [BRIGHT_W-1:0] w_den;
    logic [LVL_W:0]      w_dt;
    logic [LVL_W-1:0]    w_mag;
    logic [LVL_W+2:0]    w_lvl_s;
    logic [LVL_W-1:0]    w_lvl;
    logic [MOD_W-1:0]    w_mod_x;
    logic                w_changed;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    bldim_cfg #(
        .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_cfg_wr),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_bp       (w_bp),
        .o_cfg      (w_cfg)
    );

    bldim_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    assign w_top = w_bp[TOP];
    assign w_cur = w_bp[r_idx];

    // interpolation operands: span below the upper breakpoint times tune span
    assign w_bdiff = bp_bright(r_hi) - r_b;
    assign w_den   = bp_bright(r_hi) - bp_bright(r_lo);
    assign w_dt    = {1'b0, bp_tune(r_hi)} - {1'b0, bp_tune(r_lo)};
    assign w_mag   = w_dt[LVL_W] ? LVL_W'(-w_dt) : w_dt[LVL_W-1:0];

    // level = upper tune minus signed quotient, clamped to the level range
    assign w_lvl_s = r_neg ? ({3'b0, bp_tune(r_hi)} + {2'b0, w_div_rsp.quo[LVL_W:0]})
                           : ({3'b0, bp_tune(r_hi)} - {2'b0, w_div_rsp.quo[LVL_W:0]});
    always_comb begin
        if (w_lvl_s[LVL_W+2]) begin
            w_lvl = '0;
        end else if (w_lvl_s[LVL_W+1:LVL_W] != '0) begin
            w_lvl = '1;
        end else begin
            w_lvl = w_lvl_s[LVL_W-1:0];
        end
    end

    assign w_changed = (r_level != r_prev);
    assign w_mod_x   = MOD_W'(r_prev) + MOD_W'(MOD_OFS) - MOD_W'(r_level);

    // drive the shared divider: interpolation, then the pulse count
    always_comb begin
        w_div_req = '0;
        if (r_state == S_MUL) begin
            w_div_req.start = 1'b1;
            w_div_req.num   = DIV_NUM_W'(w_bdiff * w_mag);
            w_div_req.den   = w_den;
            w_div_req.len   = DIV_CNT_W'(DIV_NUM_W);
        end else if (r_state == S_APPLY && w_changed && r_level != '0) begin
            w_div_req.start = 1'b1;
            w_div_req.num   = DIV_NUM_W'(w_mod_x) << (DIV_NUM_W - MOD_W);
            w_div_req.den   = DIV_DEN_W'(PULSE_MODULUS);
            w_div_req.len   = DIV_CNT_W'(MOD_W);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequence one item through search, divide and apply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= LVL_W'(16);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg.prev_load) begin
                r_prev <= w_cfg.prev_value;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_b     <= i_in_data.blank ? '0 : i_in_data.req_brightness;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_b > bp_bright(w_top)) begin
                        r_res   <= '{status: 1'b1, default: '0};
                        r_state <= S_EMIT;
                    end else if (w_cfg.auto_level >= HBM_THRESHOLD &&
                                 r_b == bp_bright(w_top)) begin
                        r_res   <= '0;
                        r_level <= w_cfg.outdoor_tune;
                        r_state <= S_APPLY;
                    end else begin
                        r_res   <= '0;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == IDX_W'(TOP) || r_b <= bp_bright(w_cur)) begin
                        r_hi <= w_cur;
                        if (r_idx <= IDX_W'(1)) begin
                            r_level <= bp_tune(w_cur);
                            r_state <= S_APPLY;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_lo  <= w_cur;
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_MUL: begin
                    r_neg   <= w_dt[LVL_W];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_level <= w_lvl;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_res.dim_level <= r_level;
                    if (w_changed) begin
                        r_res.changed <= 1'b1;
                        r_prev        <= r_level;
                        if (r_level == '0) begin
                            r_res.power_off <= 1'b1;
                            r_state         <= S_EMIT;
                        end else begin
                            r_res.power_on <= (r_prev == '0);
                            r_state        <= S_MOD;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_MOD: begin
                    if (w_div_rsp.done) begin
                        r_res.pulse_count <= LVL_W'(w_div_rsp.rem);
                        r_state           <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // interpolation quotient always fits in the level width
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_rsp.done) |-> ((w_div_rsp.quo >> LVL_W) == '0))
        else $error("interpolation quotient out of level range");

    // an error beat carries nothing but its status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |->
        (r_out.dim_level == '0 && !r_out.changed && !r_out.power_on &&
         !r_out.power_off && r_out.pulse_count == '0))
        else $error("error beat with nonzero fields");

    // driver actions only come with a level change, never on and off together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.power_on || r_out.power_off || r_out.pulse_count != '0)) |->
        (r_out.changed && !(r_out.power_on && r_out.power_off)))
        else $error("driver action without a level change");

endmodule
